@@ rtl/rsim_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rsim_pkg;

  localparam int DW        = 32;
  localparam int BSW       = 9;
  localparam int MAX_BATCH = 256;
  localparam int TAB_AW    = $clog2(MAX_BATCH);
  localparam int SLOT_W    = 8;
  localparam int DIV_STEPS = DW;
  localparam int LINE      = 2 * DIV_STEPS;
  localparam int PAW       = 4;

  typedef enum logic [1:0] {
    REG_TIME_STRIDE  = 2'd0,
    REG_BATCH_STRIDE = 2'd1,
    REG_TIME_SIZE    = 2'd2,
    REG_BATCH_SIZE   = 2'd3
  } reg_idx_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MAP  = 1'b1;

  typedef struct packed {
    logic [DW-1:0]  t_step;
    logic [DW-1:0]  b_step;
    logic [DW-1:0]  t_extent;
    logic [BSW-1:0] b_extent;
  } cfg_t;

  typedef struct packed {
    logic              req;
    logic [SLOT_W-1:0] slot;
    logic [DW-1:0]     len;
    logic [DW-1:0]     idx;
  } item_t;

endpackage
`default_nettype wire

@@ rtl/rsim_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per stage, advances on en.
module rsim_div (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [rsim_pkg::DW-1:0] num,
  input  wire logic [rsim_pkg::DW-1:0] den,
  output logic      [rsim_pkg::DW-1:0] quot,
  output logic      [rsim_pkg::DW-1:0] rem
);
  import rsim_pkg::*;

  logic [DW-1:0] rem_r [DIV_STEPS];
  logic [DW-1:0] nq_r  [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic [DW-1:0] r_in;
    logic [DW-1:0] n_in;
    logic [DW:0]   r_sh;
    logic [DW:0]   diff;

    if (g == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num;
    end else begin : g_rest
      assign r_in = rem_r[g-1];
      assign n_in = nq_r[g-1];
    end

    assign r_sh = {r_in, n_in[DW-1]};
    assign diff = r_sh - {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[DW]) begin
          rem_r[g] <= diff[DW-1:0];
          nq_r[g]  <= {n_in[DW-2:0], 1'b1};
        end else begin
          rem_r[g] <= r_sh[DW-1:0];
          nq_r[g]  <= {n_in[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign quot = nq_r[DIV_STEPS-1];
  assign rem  = rem_r[DIV_STEPS-1];

endmodule
`default_nettype wire

@@ rtl/rsim_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rsim_cfg (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [rsim_pkg::PAW-1:0] paddr,
  input  wire logic [31:0]             pwdata,
  output logic      [31:0]             prdata,
  output logic                         pready,
  output rsim_pkg::cfg_t               cfg
);
  import rsim_pkg::*;

  logic     wr;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[PAW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.t_step   <= DW'(1);
      cfg.b_step   <= DW'(1);
      cfg.t_extent <= DW'(1);
      cfg.b_extent <= BSW'(1);
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (ridx)
        REG_TIME_STRIDE:  cfg.t_step   <= pwdata;
        REG_BATCH_STRIDE: cfg.b_step   <= pwdata;
        REG_TIME_SIZE:    cfg.t_extent <= pwdata;
        REG_BATCH_SIZE:   cfg.b_extent <= pwdata[BSW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_TIME_STRIDE:  prdata = cfg.t_step;
      REG_BATCH_STRIDE: prdata = cfg.b_step;
      REG_TIME_SIZE:    prdata = cfg.t_extent;
      REG_BATCH_SIZE:   prdata = {{(32-BSW){1'b0}}, cfg.b_extent};
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/reverse_sequence_index_map_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ReverseSequence source-index generator.
// Input channel (in_valid/in_stall) carries load and map items. A load item
// (req_type 0) writes length_value into the length table at batch_slot and
// produces no result. A map item (req_type 1) produces one result on the
// output channel (out_valid/out_stall): src_index and mirrored.
// Pipeline from input transfer to out_valid: 32 divider stages for the axis
// quotients, 32 for the remainders, then table read, mirror arithmetic and
// multiply, and the output register.
// Throughput: one item per cycle while the output is not stalled; the whole pipeline moves in lockstep.
// Items stay in order; a load is seen by every map that follows it.
// When the receiver stalls a held result, the pipeline freezes and in_stall
// goes high in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and sets the registers to 1. The user must write
// them over the APB port (byte address 4*index) only while idle (not enforced).
// Table entries must be loaded before a map item reads them.
module reverse_sequence_index_map_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rsim_pkg::PAW-1:0]    paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       req_type,
  input  wire logic [rsim_pkg::SLOT_W-1:0] batch_slot,
  input  wire logic [rsim_pkg::DW-1:0]     length_value,
  input  wire logic [rsim_pkg::DW-1:0]     out_index,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [rsim_pkg::DW-1:0]     src_index,
  output logic                            mirrored
);
  import rsim_pkg::*;

  cfg_t          cfg;
  logic          adv;
  logic          vld [LINE];
  item_t         itm [LINE];
  item_t         in_item;
  logic [DW-1:0] qb, qt, rb, rt;
  logic [DW-1:0] table_mem [MAX_BATCH];

  logic          m_valid, m_bcok, m_mir_ok;
  logic [DW-1:0] m_idx, m_tc, m_rd;
  logic          p_valid, p_mir;
  logic [DW-1:0] p_idx, p_d;
  logic          q_valid, q_mir;
  logic [DW-1:0] q_idx, q_prod;
  logic [DW-1:0] len, bc, tc;
  logic          bzero, tzero;

  rsim_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign in_item = '{req: req_type, slot: batch_slot, len: length_value, idx: out_index};

  rsim_div u_div_bq (.clk, .en(adv), .num(out_index), .den(cfg.b_step),
                     .quot(qb), .rem());
  rsim_div u_div_tq (.clk, .en(adv), .num(out_index), .den(cfg.t_step),
                     .quot(qt), .rem());
  rsim_div u_div_br (.clk, .en(adv), .num(qb), .den({{(DW-BSW){1'b0}}, cfg.b_extent}),
                     .quot(), .rem(rb));
  rsim_div u_div_tr (.clk, .en(adv), .num(qt), .den(cfg.t_extent),
                     .quot(), .rem(rt));

  // item sideband travels beside the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LINE; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < LINE; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      itm[0] <= in_item;
      for (int i = 1; i < LINE; i++) itm[i] <= itm[i-1];
    end
  end

  assign bzero = (cfg.b_step == '0) || (cfg.b_extent == '0);
  assign tzero = (cfg.t_step == '0) || (cfg.t_extent == '0);
  assign bc    = bzero ? '0 : rb;
  assign tc    = tzero ? '0 : rt;
  assign m_mir_ok = (bc[DW-1:TAB_AW] == '0);

  // table: loads write and maps read at the same stage, so order is kept
  always_ff @(posedge clk) begin
    if (adv) begin
      if (vld[LINE-1] && itm[LINE-1].req == REQ_LOAD)
        table_mem[itm[LINE-1].slot[TAB_AW-1:0]] <= itm[LINE-1].len;
      m_rd <= table_mem[bc[TAB_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      p_valid <= 1'b0;
      q_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_valid   <= vld[LINE-1] && itm[LINE-1].req == REQ_MAP;
      p_valid   <= m_valid;
      q_valid   <= p_valid;
      out_valid <= q_valid;
    end
  end

  assign len = m_bcok ? m_rd : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_idx  <= itm[LINE-1].idx;
      m_tc   <= tc;
      m_bcok <= m_mir_ok;
      p_idx  <= m_idx;
      p_mir  <= m_tc < len;
      // (len-1-tc) - tc, scaled by the stride in the next stage
      p_d    <= len - DW'(1) - m_tc - m_tc;
      q_idx  <= p_idx;
      q_mir  <= p_mir;
      q_prod <= DW'(p_d * cfg.t_step);
      src_index <= q_mir ? q_idx + q_prod : q_idx;
      mirrored  <= q_mir;
    end
  end

endmodule
`default_nettype wire
